@@ rtl/gic_pkg.sv @@
// ----------------------------------------------------------------------------
// gic_pkg
// Shared types and constants of the gamepad input conditioner.
// ----------------------------------------------------------------------------
package gic_pkg;

    // Item kinds carried in the input tuser bit.
    typedef enum logic {
        OP_SAMPLE      = 1'b0,
        OP_CURVE_WRITE = 1'b1
    } t_op;

    // Field widths.
    localparam int PORT_W   = 2;
    localparam int BTN_W    = 16;
    localparam int AXIS_W   = 8;
    localparam int CIDX_W   = 6;
    localparam int CVAL_W   = 7;
    localparam int WORD_W   = 20;
    localparam int TIMER_W  = 4;
    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 80;

    // Input tdata field offsets.
    localparam int IN_PORT_LSB = 0;
    localparam int IN_BTN_LSB  = IN_PORT_LSB + PORT_W;
    localparam int IN_SX_LSB   = IN_BTN_LSB + BTN_W;
    localparam int IN_SY_LSB   = IN_SX_LSB + AXIS_W;
    localparam int IN_CIDX_LSB = IN_SY_LSB + AXIS_W;
    localparam int IN_CVAL_LSB = IN_CIDX_LSB + CIDX_W;

    // Stick clamp limit and direction thresholds.
    localparam int AXIS_LIMIT = 45;
    localparam logic signed [AXIS_W-1:0] DIR_SET_POS = 8'sd27;
    localparam logic signed [AXIS_W-1:0] DIR_SET_NEG = -8'sd27;
    localparam logic signed [AXIS_W-1:0] DIR_CLR_POS = 8'sd7;
    localparam logic signed [AXIS_W-1:0] DIR_CLR_NEG = -8'sd7;

    // Direction bit positions in the held word.
    localparam int BIT_YP = 16;
    localparam int BIT_YN = 17;
    localparam int BIT_XP = 18;
    localparam int BIT_XN = 19;

    // Non-idle samples that show pressed bits before the held word repeats.
    localparam logic [TIMER_W-1:0] REPEAT_DELAY = 4'd9;

    // One conditioned sample on its way to the per-port state.
    typedef struct packed {
        logic [PORT_W-1:0]        port;
        logic [BTN_W-1:0]         buttons;
        logic signed [AXIS_W-1:0] curved_x;
        logic signed [AXIS_W-1:0] curved_y;
    } t_sample;

    // One result item.
    typedef struct packed {
        logic [WORD_W-1:0]        held_word;
        logic [WORD_W-1:0]        pressed_word;
        logic [WORD_W-1:0]        repeat_word;
        logic signed [AXIS_W-1:0] curved_x;
        logic signed [AXIS_W-1:0] curved_y;
    } t_result;

endpackage

@@ rtl/gic_curve_ram.sv @@
// ----------------------------------------------------------------------------
// gic_curve_ram
// Response curve table: one write port and two registered read ports.
// ----------------------------------------------------------------------------
module gic_curve_ram #(
    parameter int ENTRIES = 46
) (
    input  logic                        i_clk,
    input  logic                        i_wr_en,
    input  logic [$clog2(ENTRIES)-1:0]  i_wr_addr,
    input  logic [gic_pkg::CVAL_W-1:0]  i_wr_data,
    input  logic                        i_rd_en,
    input  logic [$clog2(ENTRIES)-1:0]  i_rd_addr_a,
    input  logic [$clog2(ENTRIES)-1:0]  i_rd_addr_b,
    output logic [gic_pkg::CVAL_W-1:0]  o_rd_data_a,
    output logic [gic_pkg::CVAL_W-1:0]  o_rd_data_b
);

    logic [gic_pkg::CVAL_W-1:0] r_mem [ENTRIES];
    logic [gic_pkg::CVAL_W-1:0] r_rd_data_a;
    logic [gic_pkg::CVAL_W-1:0] r_rd_data_b;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read ports, held while the pipeline stalls.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data_a <= r_mem[i_rd_addr_a];
            r_rd_data_b <= r_mem[i_rd_addr_b];
        end
    end

    assign o_rd_data_a = r_rd_data_a;
    assign o_rd_data_b = r_rd_data_b;

endmodule

@@ rtl/gic_port_state.sv @@
// ----------------------------------------------------------------------------
// gic_port_state
// Per-port held word and auto-repeat timer, with direction hysteresis.
// ----------------------------------------------------------------------------
module gic_port_state #(
    parameter int PORTS = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_update,
    input  gic_pkg::t_sample i_sample,
    output gic_pkg::t_result o_result
);

    localparam int PW = (PORTS > 1) ? $clog2(PORTS) : 1;

    logic [gic_pkg::WORD_W-1:0]  r_held  [PORTS];
    logic [gic_pkg::TIMER_W-1:0] r_timer [PORTS];

    logic [PW-1:0]                 idx;
    logic [gic_pkg::WORD_W-1:0]    prev;
    logic [gic_pkg::WORD_W-1:0]    cur;
    logic [gic_pkg::WORD_W-1:0]    pressed;
    logic [gic_pkg::WORD_W-1:0]    rep;
    logic [gic_pkg::TIMER_W-1:0]   n_timer;
    logic signed [gic_pkg::AXIS_W-1:0] cx;
    logic signed [gic_pkg::AXIS_W-1:0] cy;

    assign idx = PW'(i_sample.port);
    assign cx  = i_sample.curved_x;
    assign cy  = i_sample.curved_y;

    // New held word: fresh buttons, direction bits set, cleared or kept.
    always_comb begin
        prev = r_held[idx];
        cur  = prev;
        cur[gic_pkg::BTN_W-1:0] = i_sample.buttons;
        if (cx >= gic_pkg::DIR_SET_POS) cur[gic_pkg::BIT_XP] = 1'b1;
        if (cx <= gic_pkg::DIR_SET_NEG) cur[gic_pkg::BIT_XN] = 1'b1;
        if (cx <= gic_pkg::DIR_CLR_POS) cur[gic_pkg::BIT_XP] = 1'b0;
        if (cx >= gic_pkg::DIR_CLR_NEG) cur[gic_pkg::BIT_XN] = 1'b0;
        if (cy >= gic_pkg::DIR_SET_POS) cur[gic_pkg::BIT_YP] = 1'b1;
        if (cy <= gic_pkg::DIR_SET_NEG) cur[gic_pkg::BIT_YN] = 1'b1;
        if (cy <= gic_pkg::DIR_CLR_POS) cur[gic_pkg::BIT_YP] = 1'b0;
        if (cy >= gic_pkg::DIR_CLR_NEG) cur[gic_pkg::BIT_YN] = 1'b0;
        pressed = ~prev & cur;
    end

    // Auto-repeat: idle clears the timer, then pressed bits until the delay, then the held word.
    always_comb begin
        n_timer = r_timer[idx];
        if (cur == '0) begin
            n_timer = '0;
            rep     = '0;
        end else if (r_timer[idx] >= gic_pkg::REPEAT_DELAY) begin
            rep     = cur;
        end else begin
            n_timer = r_timer[idx] + 1'b1;
            rep     = pressed;
        end
    end

    // State update for the sample's port.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < PORTS; i++) begin
                r_held[i]  <= '0;
                r_timer[i] <= '0;
            end
        end else if (i_update) begin
            r_held[idx]  <= cur;
            r_timer[idx] <= n_timer;
        end
    end

    assign o_result.held_word    = cur;
    assign o_result.pressed_word = pressed;
    assign o_result.repeat_word  = rep;
    assign o_result.curved_x     = cx;
    assign o_result.curved_y     = cy;

endmodule

@@ rtl/gamepad_input_conditioner.sv @@
// ----------------------------------------------------------------------------
// gamepad_input_conditioner
// Clamps and curves stick axes, derives direction bits and button events.
// ----------------------------------------------------------------------------
// The block takes one item per clock cycle while the result side keeps up; a
// result transfer held back by the receiver stalls the input once both stages
// are full. Once a controller sample is accepted, its first stage reads the
// response curve through the registered read ports of the curve memory, and
// its second stage updates the port's held word and repeat timer and loads
// the result register. A curve write gives no result, and neither does a
// sample for a port beyond PORTS or a write beyond the table.
// A curve entry must be written before any sample reads it.
module gamepad_input_conditioner #(
    parameter int PORTS         = 4,
    parameter int CURVE_ENTRIES = 46
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // port[1:0], buttons[17:2], stick_x[25:18], stick_y[33:26],
    // curve_index[39:34], curve_value[46:40], zero fill[47]
    input  logic [gic_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // op[0]
    input  logic [0:0]                        s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // held_word[19:0], pressed_word[39:20], repeat_word[59:40],
    // curved_x[67:60], curved_y[75:68], zero fill[79:76]
    output logic [gic_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);

    localparam int CW  = $clog2(CURVE_ENTRIES);
    localparam int LIM = (gic_pkg::AXIS_LIMIT > CURVE_ENTRIES - 1) ?
                         CURVE_ENTRIES - 1 : gic_pkg::AXIS_LIMIT;
    localparam logic [gic_pkg::AXIS_W-1:0] LIM_MAG = gic_pkg::AXIS_W'(LIM);

    // Input field unpacking.
    gic_pkg::t_op                 in_op;
    logic [gic_pkg::PORT_W-1:0]   in_port;
    logic [gic_pkg::BTN_W-1:0]    in_buttons;
    logic [gic_pkg::AXIS_W-1:0]   in_sx;
    logic [gic_pkg::AXIS_W-1:0]   in_sy;
    logic [gic_pkg::CIDX_W-1:0]   in_cidx;
    logic [gic_pkg::CVAL_W-1:0]   in_cval;

    assign in_op      = gic_pkg::t_op'(s_axis_tuser[0]);
    assign in_port    = s_axis_tdata[gic_pkg::IN_PORT_LSB +: gic_pkg::PORT_W];
    assign in_buttons = s_axis_tdata[gic_pkg::IN_BTN_LSB +: gic_pkg::BTN_W];
    assign in_sx      = s_axis_tdata[gic_pkg::IN_SX_LSB +: gic_pkg::AXIS_W];
    assign in_sy      = s_axis_tdata[gic_pkg::IN_SY_LSB +: gic_pkg::AXIS_W];
    assign in_cidx    = s_axis_tdata[gic_pkg::IN_CIDX_LSB +: gic_pkg::CIDX_W];
    assign in_cval    = s_axis_tdata[gic_pkg::IN_CVAL_LSB +: gic_pkg::CVAL_W];

    // Pipeline control.
    logic r_s1_valid;
    logic r_out_valid;
    logic out_free;
    logic s1_advance;
    logic in_xfer;
    logic in_sample_ok;
    logic wr_en;

    assign out_free      = !r_out_valid || m_axis_tready;
    assign s1_advance    = r_s1_valid && out_free;
    assign s_axis_tready = !r_s1_valid || out_free;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign in_sample_ok  = (in_op == gic_pkg::OP_SAMPLE) && (32'(in_port) < PORTS);
    assign wr_en         = in_xfer && (in_op == gic_pkg::OP_CURVE_WRITE) &&
                           (32'(in_cidx) < CURVE_ENTRIES);

    // Axis magnitude, clamped to the limit and the table length.
    logic [gic_pkg::AXIS_W-1:0] mag_x;
    logic [gic_pkg::AXIS_W-1:0] mag_y;
    logic [gic_pkg::AXIS_W-1:0] clamp_x;
    logic [gic_pkg::AXIS_W-1:0] clamp_y;

    always_comb begin
        mag_x   = in_sx[gic_pkg::AXIS_W-1] ? (gic_pkg::AXIS_W'(0) - in_sx) : in_sx;
        mag_y   = in_sy[gic_pkg::AXIS_W-1] ? (gic_pkg::AXIS_W'(0) - in_sy) : in_sy;
        clamp_x = (mag_x > LIM_MAG) ? LIM_MAG : mag_x;
        clamp_y = (mag_y > LIM_MAG) ? LIM_MAG : mag_y;
    end

    logic [gic_pkg::CVAL_W-1:0] curve_x;
    logic [gic_pkg::CVAL_W-1:0] curve_y;

    gic_curve_ram #(
        .ENTRIES (CURVE_ENTRIES)
    ) u_curve (
        .i_clk       (i_clk),
        .i_wr_en     (wr_en),
        .i_wr_addr   (CW'(in_cidx)),
        .i_wr_data   (in_cval),
        .i_rd_en     (s_axis_tready),
        .i_rd_addr_a (CW'(clamp_x)),
        .i_rd_addr_b (CW'(clamp_y)),
        .o_rd_data_a (curve_x),
        .o_rd_data_b (curve_y)
    );

    // First stage registers beside the curve read data.
    logic                       r_s1_neg_x;
    logic                       r_s1_neg_y;
    logic [gic_pkg::PORT_W-1:0] r_s1_port;
    logic [gic_pkg::BTN_W-1:0]  r_s1_buttons;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_s1_valid <= in_xfer && in_sample_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready) begin
            r_s1_neg_x   <= in_sx[gic_pkg::AXIS_W-1];
            r_s1_neg_y   <= in_sy[gic_pkg::AXIS_W-1];
            r_s1_port    <= in_port;
            r_s1_buttons <= in_buttons;
        end
    end

    // Sign restored on the curve values.
    gic_pkg::t_sample s1_sample;

    always_comb begin
        s1_sample.port     = r_s1_port;
        s1_sample.buttons  = r_s1_buttons;
        s1_sample.curved_x = r_s1_neg_x ? (gic_pkg::AXIS_W'(0) - {1'b0, curve_x})
                                        : {1'b0, curve_x};
        s1_sample.curved_y = r_s1_neg_y ? (gic_pkg::AXIS_W'(0) - {1'b0, curve_y})
                                        : {1'b0, curve_y};
    end

    gic_pkg::t_result s2_result;

    gic_port_state #(
        .PORTS (PORTS)
    ) u_state (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_update (s1_advance),
        .i_sample (s1_sample),
        .o_result (s2_result)
    );

    // Result register.
    gic_pkg::t_result r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_advance) begin
            r_out <= s2_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'b0000, r_out.curved_y, r_out.curved_x,
                            r_out.repeat_word, r_out.pressed_word, r_out.held_word};

    // Checks.
    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && r_out_valid && !m_axis_tready |-> !s_axis_tready)
        else $error("input taken while both stages are stalled");

    a_write_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer && (in_op == gic_pkg::OP_CURVE_WRITE) |=> !r_s1_valid)
        else $error("curve write entered the sample pipeline");

    a_pressed_in_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> ((r_out.pressed_word & ~r_out.held_word) == '0))
        else $error("pressed bit not present in held word");

    a_reset_clears_output: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

endmodule
